>>> hw/rtl/mrm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and region decode tables for the holding-register map.
package mrm_pkg;

  localparam int DataWords   = 10000;
  localparam int IoWords     = 64;
  localparam int RopWords    = 2000;
  localparam int SmWords     = 1000;
  localparam int BackupWords = 4096;

  localparam int RegDepth = DataWords + 6 * IoWords + RopWords + 2 * SmWords + 2 * BackupWords;
  localparam int SlotW    = $clog2(RegDepth);
  localparam int WordW    = 16;
  localparam int AddrW    = 16;
  localparam int RegionCount = 12;
  localparam int RegionW  = $clog2(RegionCount);

  localparam logic [AddrW-1:0] EndMark = 16'hffff;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam int Start0  = 0;
  localparam int Start1  = 10000;
  localparam int Start2  = 10200;
  localparam int Start3  = 10400;
  localparam int Start4  = 10600;
  localparam int Start5  = 10800;
  localparam int Start6  = 11000;
  localparam int Start7  = 15000;
  localparam int Start8  = 17000;
  localparam int Start9  = 20000;
  localparam int Start10 = 30000;
  localparam int Start11 = 40000;

  localparam int Base0  = 0;
  localparam int Base1  = Base0 + DataWords;
  localparam int Base2  = Base1 + IoWords;
  localparam int Base3  = Base2 + IoWords;
  localparam int Base4  = Base3 + IoWords;
  localparam int Base5  = Base4 + IoWords;
  localparam int Base6  = Base5 + IoWords;
  localparam int Base7  = Base6 + IoWords;
  localparam int Base8  = Base7 + RopWords;
  localparam int Base9  = Base8 + SmWords;
  localparam int Base10 = Base9 + BackupWords;
  localparam int Base11 = Base10 + SmWords;

  typedef struct packed {
    logic                    cmd;
    logic [AddrW-1:0]        reg_address;
    logic signed [WordW-1:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordW-1:0] read_data;
    logic                    hit;
  } out_beat_t;

  typedef struct packed {
    logic                    cmd;
    logic                    hit;
    logic [SlotW-1:0]        slot;
    logic signed [WordW-1:0] wdata;
  } op_t;

  function automatic logic [AddrW:0] region_start(input logic [RegionW-1:0] r);
    logic [AddrW:0] v;
    case (r)
      4'd0:    v = (AddrW+1)'(Start0);
      4'd1:    v = (AddrW+1)'(Start1);
      4'd2:    v = (AddrW+1)'(Start2);
      4'd3:    v = (AddrW+1)'(Start3);
      4'd4:    v = (AddrW+1)'(Start4);
      4'd5:    v = (AddrW+1)'(Start5);
      4'd6:    v = (AddrW+1)'(Start6);
      4'd7:    v = (AddrW+1)'(Start7);
      4'd8:    v = (AddrW+1)'(Start8);
      4'd9:    v = (AddrW+1)'(Start9);
      4'd10:   v = (AddrW+1)'(Start10);
      4'd11:   v = (AddrW+1)'(Start11);
      default: v = '1;
    endcase
    return v;
  endfunction

  // Start minus packed base, so the store index is one subtraction.
  function automatic logic [AddrW:0] region_delta(input logic [RegionW-1:0] r);
    logic [AddrW:0] v;
    case (r)
      4'd0:    v = (AddrW+1)'(Start0 - Base0);
      4'd1:    v = (AddrW+1)'(Start1 - Base1);
      4'd2:    v = (AddrW+1)'(Start2 - Base2);
      4'd3:    v = (AddrW+1)'(Start3 - Base3);
      4'd4:    v = (AddrW+1)'(Start4 - Base4);
      4'd5:    v = (AddrW+1)'(Start5 - Base5);
      4'd6:    v = (AddrW+1)'(Start6 - Base6);
      4'd7:    v = (AddrW+1)'(Start7 - Base7);
      4'd8:    v = (AddrW+1)'(Start8 - Base8);
      4'd9:    v = (AddrW+1)'(Start9 - Base9);
      4'd10:   v = (AddrW+1)'(Start10 - Base10);
      4'd11:   v = (AddrW+1)'(Start11 - Base11);
      default: v = '0;
    endcase
    return v;
  endfunction

  // First address past the end of each region.
  function automatic logic [AddrW:0] region_end(input logic [RegionW-1:0] r);
    logic [AddrW:0] v;
    case (r)
      4'd0:    v = (AddrW+1)'(Start0 + DataWords);
      4'd1:    v = (AddrW+1)'(Start1 + IoWords);
      4'd2:    v = (AddrW+1)'(Start2 + IoWords);
      4'd3:    v = (AddrW+1)'(Start3 + IoWords);
      4'd4:    v = (AddrW+1)'(Start4 + IoWords);
      4'd5:    v = (AddrW+1)'(Start5 + IoWords);
      4'd6:    v = (AddrW+1)'(Start6 + IoWords);
      4'd7:    v = (AddrW+1)'(Start7 + RopWords);
      4'd8:    v = (AddrW+1)'(Start8 + SmWords);
      4'd9:    v = (AddrW+1)'(Start9 + BackupWords);
      4'd10:   v = (AddrW+1)'(Start10 + SmWords);
      4'd11:   v = (AddrW+1)'(Start11 + BackupWords);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/mrm_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module mrm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mrm_front.sv
`timescale 1ns / 1ps
// Front end: accepts accesses and decodes the address into region hit and store index.
module mrm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             busy_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mrm_pkg::in_beat_t in_beat_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output mrm_pkg::op_t     op_o
);
  import mrm_pkg::*;

  logic [RegionW-1:0] sel;
  logic [AddrW:0]     addr_ext;
  logic [AddrW:0]     slot_full;
  op_t                op_d;
  op_t                op_q;
  logic               valid_q;
  logic               accept;

  assign addr_ext = {1'b0, in_beat_i.reg_address};

  always_comb begin
    sel = '0;
    for (int r = 0; r < RegionCount; r++) begin
      if (addr_ext >= region_start(RegionW'(r))) begin
        sel = RegionW'(r);
      end
    end
  end

  assign slot_full = addr_ext - region_delta(sel);

  always_comb begin
    op_d.cmd   = in_beat_i.cmd;
    op_d.hit   = (in_beat_i.reg_address != EndMark) && (addr_ext < region_end(sel));
    op_d.slot  = slot_full[SlotW-1:0];
    op_d.wdata = in_beat_i.write_data;
  end

  assign in_stall_o = busy_i | (valid_q & ~op_ready_i);
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (op_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

>>> hw/rtl/mrm_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded accesses between the front and back ends.
module mrm_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mrm_pkg::op_t in_op_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mrm_pkg::op_t out_op_o
);
  import mrm_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       push;
  logic       pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;
  assign out_op_o    = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_op_i;
    end
  end

endmodule

>>> hw/rtl/mrm_back.sv
`timescale 1ns / 1ps
// Back end: clears the word store after reset, performs accesses and holds the result beat.
module mrm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              busy_o,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  mrm_pkg::op_t      op_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mrm_pkg::out_beat_t out_beat_o
);
  import mrm_pkg::*;

  logic             clr_busy_q;
  logic [SlotW-1:0] clr_cnt_q;
  logic             p_valid_q;
  logic             p_cmd_q;
  logic             p_hit_q;
  logic             out_valid_q;
  out_beat_t        out_beat_q;
  out_beat_t        out_beat_d;
  logic             p_adv;
  logic             pop;
  logic             ram_en;
  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [WordW-1:0] ram_wdata;
  logic [WordW-1:0] ram_rdata;

  assign p_adv      = ~out_valid_q | ~out_stall_i;
  assign op_ready_o = ~clr_busy_q & (~p_valid_q | p_adv);
  assign pop        = op_valid_i & op_ready_o;

  assign ram_en    = clr_busy_q | (pop & op_i.hit);
  assign ram_we    = clr_busy_q | (op_i.cmd == CmdWrite);
  assign ram_addr  = clr_busy_q ? clr_cnt_q : op_i.slot;
  assign ram_wdata = clr_busy_q ? '0 : op_i.wdata;

  mrm_ram #(
    .Width(WordW),
    .Depth(RegDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + SlotW'(1);
      if (clr_cnt_q == SlotW'(RegDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (pop) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_cmd_q <= op_i.cmd;
      p_hit_q <= op_i.hit;
    end
  end

  always_comb begin
    out_beat_d.hit       = p_hit_q;
    out_beat_d.read_data = (p_hit_q && p_cmd_q == CmdRead) ? ram_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_valid_q && p_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q && p_adv) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign busy_o      = clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

>>> hw/rtl/modbus_register_map.sv
`timescale 1ns / 1ps
// Top level of the holding-register map: front decode, access queue and back end.
//
// Each input beat on in_valid_i/in_stall_o carries a read or write command, a 16-bit
// register address and write data. The front end decodes the address against twelve
// fixed regions into a hit flag and an index into one shared word store. A queue of
// two decoded accesses separates the front end from the back end, which holds the
// store in a single-port RAM with registered read data.
// Every access returns exactly one beat on out_valid_o/out_stall_i: the stored word
// and hit set for an in-range read, zero data with hit reporting the store for a
// write, and zero data with hit low for an unmapped address.
// An accepted access passes the front register, a queue entry, the RAM read stage and the output register.
// Throughput is one access per cycle while the store is not being cleared and the receiver does not stall;
// the single RAM port sets that figure. After reset the back end sweeps every word of the store to zero,
// one word per cycle; in_stall_o stays high until the sweep is done.
// When the receiver stalls, the result beat holds, the queue fills and in_stall_o
// rises once the front register can no longer hand off its beat.
module modbus_register_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrm_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrm_pkg::out_beat_t  out_beat_o
);
  import mrm_pkg::*;

  logic busy;
  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic b_valid;
  logic b_ready;
  op_t  b_op;

  mrm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_i    (busy),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_beat_i (in_beat_i),
    .op_valid_o(f_valid),
    .op_ready_i(f_ready),
    .op_o      (f_op)
  );

  mrm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_op_i    (f_op),
    .out_valid_o(b_valid),
    .out_ready_i(b_ready),
    .out_op_o   (b_op)
  );

  mrm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (busy),
    .op_valid_i (b_valid),
    .op_ready_o (b_ready),
    .op_i       (b_op),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule

>>> dv/modbus_register_map_checker.sv
`timescale 1ns / 1ps
// Checker for the holding-register map: predicts every result beat and compares it.
module modbus_register_map_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  mrm_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  mrm_pkg::out_beat_t out_beat_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  import mrm_pkg::*;

  localparam int ReportLimit = 10;

  int region_first [RegionCount] = '{0, 10000, 10200, 10400, 10600, 10800,
                                     11000, 15000, 17000, 20000, 30000, 40000};
  int region_words [RegionCount] = '{DataWords, IoWords, IoWords, IoWords, IoWords,
                                     IoWords, IoWords, RopWords, SmWords, BackupWords,
                                     SmWords, BackupWords};

  logic [WordW-1:0] shadow_words [int];
  out_beat_t        expected_q [$];
  int               fail_count = 0;
  int               checked = 0;

  function automatic bit locate_word(input logic [AddrW-1:0] addr, output int slot);
    int sel;
    int base;
    int i;
    sel = 0;
    base = 0;
    slot = 0;
    if (addr == EndMark) return 1'b0;
    for (i = 0; i < RegionCount; i++) begin
      if (int'(addr) >= region_first[i]) sel = i;
    end
    for (i = 0; i < sel; i++) base += region_words[i];
    if (int'(addr) - region_first[sel] >= region_words[sel]) return 1'b0;
    if (base + int'(addr) - region_first[sel] >= RegDepth) return 1'b0;
    slot = base + int'(addr) - region_first[sel];
    return 1'b1;
  endfunction

  function automatic out_beat_t access_register(input in_beat_t b);
    out_beat_t r;
    int        slot;
    bit        hit;
    hit = locate_word(b.reg_address, slot);
    r.read_data = '0;
    r.hit = hit;
    if (hit && b.cmd == CmdWrite) begin
      shadow_words[slot] = b.write_data;
    end else if (hit && shadow_words.exists(slot)) begin
      r.read_data = shadow_words[slot];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      shadow_words.delete();
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(access_register(in_beat_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("Unexpected result beat: read_data=%0d hit=%0b",
                     out_beat_i.read_data, out_beat_i.hit);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_beat_i.read_data !== want.read_data || out_beat_i.hit !== want.hit) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display("Result %0d: expected read_data=%0d hit=%0b, got read_data=%0d hit=%0b",
                       checked, want.read_data, want.hit, out_beat_i.read_data,
                       out_beat_i.hit);
            end
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o <= expected_q.size();
    checked_o <= checked;
  end

endmodule

>>> dv/modbus_register_map_tb.sv
`timescale 1ns / 1ps
// Testbench top for the holding-register map: clock, reset, stimulus and verdict.
module modbus_register_map_tb;
  import mrm_pkg::*;

  localparam int QuietLimit   = 100000;
  localparam int PhaseItems   = 470;
  localparam int SettleCycles = 20;
  localparam int RecentDepth  = 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_beat_t  in_beat = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int fail_count;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int reads_sent = 0;
  int writes_sent = 0;

  int region_first [RegionCount] = '{0, 10000, 10200, 10400, 10600, 10800,
                                     11000, 15000, 17000, 20000, 30000, 40000};
  int region_words [RegionCount] = '{DataWords, IoWords, IoWords, IoWords, IoWords,
                                     IoWords, IoWords, RopWords, SmWords, BackupWords,
                                     SmWords, BackupWords};

  logic [AddrW-1:0] written_addrs [$];

  modbus_register_map dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  modbus_register_map_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no beat accepted in %0d cycles.", QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_beat_t make_access(input logic cmd, input int addr, input int data);
    in_beat_t b;
    b.cmd = cmd;
    b.reg_address = addr[AddrW-1:0];
    b.write_data = data[WordW-1:0];
    return b;
  endfunction

  function automatic in_beat_t random_access();
    in_beat_t b;
    int       pick;
    int       region;
    int       first;
    int       words;
    int       offset;
    pick = $urandom_range(99);
    region = $urandom_range(RegionCount - 1);
    first = region_first[region];
    words = region_words[region];
    b.cmd = $urandom_range(1) ? CmdWrite : CmdRead;
    case ($urandom_range(9))
      0: b.write_data = 16'h7fff;
      1: b.write_data = 16'h8000;
      default: b.write_data = WordW'($urandom);
    endcase
    if (pick < 55) begin
      if ($urandom_range(9) == 0) offset = $urandom_range(1) ? 0 : words - 1;
      else offset = $urandom_range(words - 1);
      b.reg_address = AddrW'(first + offset);
    end else if (pick < 75 && written_addrs.size() > 0) begin
      b.reg_address = written_addrs[$urandom_range(written_addrs.size() - 1)];
      b.cmd = ($urandom_range(4) != 0) ? CmdRead : CmdWrite;
    end else if (pick < 88) begin
      b.reg_address = AddrW'(first + words + $urandom_range(3));
    end else if (pick < 91) begin
      b.reg_address = EndMark;
    end else begin
      b.reg_address = AddrW'($urandom_range(16'hffff));
    end
    return b;
  endfunction

  task automatic send_access(input in_beat_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (b.cmd == CmdWrite) begin
      writes_sent++;
      written_addrs.push_back(b.reg_address);
      if (written_addrs.size() > RecentDepth) void'(written_addrs.pop_front());
    end else begin
      reads_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (PhaseItems) send_access(random_access());
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_access(make_access(CmdRead, 0, 0));
    send_access(make_access(CmdWrite, 0, 16'h7fff));
    send_access(make_access(CmdRead, 0, 0));
    send_access(make_access(CmdWrite, 9999, 16'h8000));
    send_access(make_access(CmdRead, 9999, 16'hffff));
    send_access(make_access(CmdRead, 10000, 0));
    send_access(make_access(CmdWrite, 10063, 16'h5a5a));
    send_access(make_access(CmdRead, 10063, 0));
    send_access(make_access(CmdWrite, 10064, 16'hffff));
    send_access(make_access(CmdRead, 10064, 0));
    send_access(make_access(CmdWrite, 11063, 16'h1234));
    send_access(make_access(CmdRead, 11063, 0));
    send_access(make_access(CmdWrite, 15000, 16'hfffe));
    send_access(make_access(CmdRead, 16999, 0));
    send_access(make_access(CmdWrite, 17999, 16'h0001));
    send_access(make_access(CmdRead, 18000, 0));
    send_access(make_access(CmdWrite, 24095, 16'ha5a5));
    send_access(make_access(CmdRead, 24096, 0));
    send_access(make_access(CmdWrite, 30999, 16'h8001));
    send_access(make_access(CmdRead, 30999, 0));
    send_access(make_access(CmdWrite, 44095, 16'h7ffe));
    send_access(make_access(CmdRead, 44095, 0));
    send_access(make_access(CmdRead, EndMark, 0));
    send_access(make_access(CmdWrite, EndMark, 16'h5555));
    send_access(make_access(CmdRead, 16'hfffe, 0));
    drain_results();

    run_phase(0, 0);
    run_phase(85, 0);
    run_phase(0, 85);
    run_phase(33, 33);

    stall_pct <= 0;
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d writes and %0d reads over all twelve regions, the gaps past each",
             writes_sent, reads_sent);
    $display("region and the end marker; %0d result beats checked, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
